// ----- rtl/combinadic_mask_rank_unrank_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the combinadic mask rank / unrank unit
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef COMBINADIC_MASK_RANK_UNRANK_UNIT_MACROS_SVH
`define COMBINADIC_MASK_RANK_UNRANK_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// cond holds -> expr holds in the same cycle
`define CMRU_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("cmru: implication check failed");

// cond holds -> expr holds in the next cycle
`define CMRU_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("cmru: next-cycle check failed");

`else

`define CMRU_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define CMRU_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ----- rtl/cmru_pkg.sv -----
// ----------------------------------------------------------------------------
// cmru_pkg
// Shared types, constants and the binomial row builder for the rank unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmru_pkg;

	localparam int MAX_BITS_DEF = 30;
	localparam int RANK_W       = 28;
	localparam int CNT_W        = 5;
	localparam int ROW_LEN      = 32;

	localparam logic [CNT_W-1:0] WIDTH_RST = 5'd30;
	localparam logic [CNT_W-1:0] WIDTH_MIN = 5'd2;

	localparam logic KIND_RANK   = 1'b0;
	localparam logic KIND_UNRANK = 1'b1;

	// C(a, b) for b = 0..31, zero where b > a
	typedef logic [ROW_LEN-1:0][RANK_W-1:0] binom_row_t;

	// token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              kind;
		logic [RANK_W-1:0] rank;   // rank: running sum, unrank: residual
		logic [CNT_W-1:0]  cnt;    // rank: ones seen, unrank: ones left
		logic              flag;   // rank: high bits set
	} cmru_token_t;

	function automatic binom_row_t binom_row(input int a);
		binom_row_t row;
		row    = '0;
		row[0] = 28'd1;
		for (int r = 1; r <= a; r++) begin
			for (int b = ROW_LEN - 1; b >= 1; b--) begin
				row[b] = row[b] + row[b-1];
			end
		end
		return row;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/cmru_cell.sv -----
// ----------------------------------------------------------------------------
// cmru_cell
// One bit position of the chain: rank step at bit IDX, unrank step at the
// mirrored bit, one register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmru_cell #(
	parameter int MAX_BITS = cmru_pkg::MAX_BITS_DEF,
	parameter int IDX      = 0
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire logic [cmru_pkg::CNT_W-1:0]       n,
	input  wire cmru_pkg::cmru_token_t            tok_in,
	input  wire logic [MAX_BITS-1:0]              mask_in,
	output cmru_pkg::cmru_token_t                 tok_out,
	output logic [MAX_BITS-1:0]                   mask_out
);

	localparam int                         IDX_U = MAX_BITS - 1 - IDX;
	localparam logic [cmru_pkg::CNT_W-1:0] POS_R = cmru_pkg::CNT_W'(IDX);
	localparam logic [cmru_pkg::CNT_W-1:0] POS_U = cmru_pkg::CNT_W'(IDX_U);
	localparam cmru_pkg::binom_row_t       ROW_R = cmru_pkg::binom_row(IDX);
	localparam cmru_pkg::binom_row_t       ROW_U = cmru_pkg::binom_row(IDX_U);

	cmru_pkg::cmru_token_t                tok_d;
	logic [MAX_BITS-1:0]                  mask_d;
	logic [cmru_pkg::CNT_W-1:0]           sel_r;
	logic [cmru_pkg::RANK_W-1:0]          coef_r;
	logic [cmru_pkg::RANK_W-1:0]          coef_u;
	cmru_pkg::cmru_token_t                tok_q;
	logic [MAX_BITS-1:0]                  mask_q;

	assign sel_r  = tok_in.cnt + 5'd1;
	assign coef_r = ROW_R[sel_r];
	assign coef_u = ROW_U[tok_in.cnt];

	always_comb begin
		tok_d  = tok_in;
		mask_d = mask_in;
		if (tok_in.kind == cmru_pkg::KIND_RANK) begin
			if ((POS_R < n) && mask_in[IDX]) begin
				tok_d.rank = tok_in.rank + coef_r;
				tok_d.cnt  = sel_r;
			end
		end else begin
			if ((POS_U < n) && (tok_in.cnt != '0) && (tok_in.rank >= coef_u)) begin
				tok_d.rank    = tok_in.rank - coef_u;
				tok_d.cnt     = tok_in.cnt - 5'd1;
				mask_d[IDX_U] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			mask_q <= '0;
		end else begin
			tok_q  <= tok_d;
			mask_q <= mask_d;
		end
	end

	assign tok_out  = tok_q;
	assign mask_out = mask_q;

endmodule

`default_nettype wire

// ----- rtl/combinadic_mask_rank_unrank_unit.sv -----
// ----------------------------------------------------------------------------
// combinadic_mask_rank_unrank_unit
// Combinatorial number system rank of a fixed-weight mask, and the inverse.
// ----------------------------------------------------------------------------
// Takes one request per clock: busy is low at all times except the first
// cycle after reset. Each request passes through a chain of MAX_BITS cells,
// one per bit position, and its result is shown on the result ports
// for one cycle with done high. There is
// no back-pressure: the receiver must take every result in the cycle it is
// shown. The width register is written through cfg_valid / cfg_ready
// (always ready) and must only change while no request is in the chain.
`timescale 1ns / 1ps
`default_nettype none
`include "combinadic_mask_rank_unrank_unit_macros.svh"

module combinadic_mask_rank_unrank_unit #(
	parameter int MAX_BITS = cmru_pkg::MAX_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [cmru_pkg::CNT_W-1:0]    cfg_data,
	input  wire                                start,
	output logic                               busy,
	input  wire logic                          kind,
	input  wire logic [MAX_BITS-1:0]           mask_in,
	input  wire logic [cmru_pkg::RANK_W-1:0]   rank_in,
	input  wire logic [cmru_pkg::CNT_W-1:0]    ones_wanted,
	output logic                               done,
	output logic [MAX_BITS-1:0]                mask_out,
	output logic [cmru_pkg::RANK_W-1:0]        rank_out,
	output logic [cmru_pkg::CNT_W-1:0]         ones_count,
	output logic                               out_of_range
);

	localparam logic [cmru_pkg::CNT_W-1:0] WIDTH_MAX = cmru_pkg::CNT_W'(MAX_BITS);

	logic [cmru_pkg::CNT_W-1:0] width_q;
	logic [cmru_pkg::CNT_W-1:0] n;
	logic                       busy_q;
	logic [MAX_BITS-1:0]        hi_bits;
	cmru_pkg::cmru_token_t      tok   [0:MAX_BITS];
	logic [MAX_BITS-1:0]        msk   [0:MAX_BITS];
	cmru_pkg::cmru_token_t      last;

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= cmru_pkg::WIDTH_RST;
			busy_q  <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				width_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (width_q < cmru_pkg::WIDTH_MIN) begin
			n = cmru_pkg::WIDTH_MIN;
		end else if (width_q > WIDTH_MAX) begin
			n = WIDTH_MAX;
		end else begin
			n = width_q;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_BITS; i++) begin
			hi_bits[i] = mask_in[i] && (cmru_pkg::CNT_W'(i) >= n);
		end
	end

	// chain entry
	always_comb begin
		tok[0].valid = start && !busy;
		tok[0].kind  = kind;
		if (kind == cmru_pkg::KIND_UNRANK) begin
			tok[0].rank = rank_in;
			tok[0].cnt  = ones_wanted;
			tok[0].flag = 1'b0;
			msk[0]      = '0;
		end else begin
			tok[0].rank = '0;
			tok[0].cnt  = '0;
			tok[0].flag = |hi_bits;
			msk[0]      = mask_in;
		end
	end

	for (genvar k = 0; k < MAX_BITS; k++) begin : g_cell
		cmru_cell #(
			.MAX_BITS (MAX_BITS),
			.IDX      (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.n        (n),
			.tok_in   (tok[k]),
			.mask_in  (msk[k]),
			.tok_out  (tok[k+1]),
			.mask_out (msk[k+1])
		);
	end

	assign last = tok[MAX_BITS];
	assign done = last.valid;

	always_comb begin
		if (last.kind == cmru_pkg::KIND_UNRANK) begin
			mask_out     = msk[MAX_BITS];
			rank_out     = '0;
			ones_count   = '0;
			// leftover residual or ones means rank >= C(n, p)
			out_of_range = (last.rank != '0) || (last.cnt != '0);
		end else begin
			mask_out     = '0;
			rank_out     = last.rank;
			ones_count   = last.cnt;
			out_of_range = last.flag;
		end
	end

	`CMRU_ASSERT_IMPLIES(a_done_latency, clk, arst_n, done, $past(start && !busy, MAX_BITS))
	`CMRU_ASSERT_IMPLIES(a_rank_ones, clk, arst_n,
		done && (last.kind == cmru_pkg::KIND_RANK) && !out_of_range,
		$countones($past(mask_in, MAX_BITS)) == int'(ones_count))
	`CMRU_ASSERT_IMPLIES(a_unrank_ones, clk, arst_n,
		done && (last.kind == cmru_pkg::KIND_UNRANK) && !out_of_range,
		$countones(mask_out) == int'($past(ones_wanted, MAX_BITS)))
	`CMRU_ASSERT_NEXT(a_busy_low, clk, arst_n, !busy, !busy)

endmodule

`default_nettype wire
